### rtl/assert_macros.svh
// Assertion macros shared by the frame checker RTL.
// Plain text macros only; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFC_ASSERT_NOW(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("sfc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SFC_ASSERT_NEXT(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("sfc assertion failed");

`endif

### rtl/sfc_pkg.sv
// Types and constants of the stream frame checker.
// No dependencies; imported by every module of the block.
package sfc_pkg;

    localparam int unsigned POS_W      = 34;
    localparam int unsigned CFG_ADDR_W = 4;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [POS_W-1:0] POS_MAX     = {POS_W{1'b1}};
    localparam logic [POS_W-1:0] POS_VERSION = POS_W'(4);
    localparam logic [POS_W-1:0] POS_KIND    = POS_W'(5);
    localparam logic [POS_W-1:0] POS_LEN0    = POS_W'(6);
    localparam logic [POS_W-1:0] HDR_LEN     = POS_W'(10);
    localparam logic [POS_W-1:0] LAST_HDR    = POS_W'(9);

    localparam logic [31:0] HB_LEN      = 32'd8;
    localparam logic [7:0]  VERSION_ONE = 8'd1;

    localparam logic [7:0] MAGIC [4] = '{8'h41, 8'h54, 8'h52, 8'h4E};

    localparam logic [31:0] RST_MAX_APP   = 32'd65536;
    localparam logic [7:0]  RST_CODE_APP  = 8'd0;
    localparam logic [7:0]  RST_CODE_PING = 8'd1;
    localparam logic [7:0]  RST_CODE_PONG = 8'd2;

    typedef enum logic [2:0] {
        ST_OK,
        ST_SHORT,
        ST_MAGIC,
        ST_VERSION,
        ST_KIND,
        ST_LEN_MISMATCH,
        ST_APP_TOO_BIG,
        ST_HB_SIZE
    } sfc_status_t;

    typedef enum logic [1:0] {
        REG_MAX_APP,
        REG_CODE_APP,
        REG_CODE_PING,
        REG_CODE_PONG
    } sfc_reg_idx_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } sfc_in_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        frame_done;
        sfc_status_t status;
        logic [7:0]  kind_code;
    } sfc_out_t;

    typedef struct packed {
        logic [31:0] max_app_payload;
        logic [7:0]  code_application;
        logic [7:0]  code_ping;
        logic [7:0]  code_pong;
    } sfc_cfg_t;

endpackage

### rtl/sfc_cfg_regs.sv
// APB register file of the stream frame checker.
// Depends on sfc_pkg for the register map and the config struct.
module sfc_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sfc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sfc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [sfc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output sfc_pkg::sfc_cfg_t              cfg
);
    import sfc_pkg::*;

    sfc_cfg_t     cfg_reg;
    sfc_cfg_t     cfg_next;
    sfc_reg_idx_t idx;
    logic         wr_en;

    assign idx    = sfc_reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_MAX_APP:   cfg_next.max_app_payload  = pwdata;
                REG_CODE_APP:  cfg_next.code_application = pwdata[7:0];
                REG_CODE_PING: cfg_next.code_ping        = pwdata[7:0];
                REG_CODE_PONG: cfg_next.code_pong        = pwdata[7:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MAX_APP:   prdata = cfg_reg.max_app_payload;
            REG_CODE_APP:  prdata = {24'd0, cfg_reg.code_application};
            REG_CODE_PING: prdata = {24'd0, cfg_reg.code_ping};
            REG_CODE_PONG: prdata = {24'd0, cfg_reg.code_pong};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_app_payload  <= RST_MAX_APP;
            cfg_reg.code_application <= RST_CODE_APP;
            cfg_reg.code_ping        <= RST_CODE_PING;
            cfg_reg.code_pong        <= RST_CODE_PONG;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/sfc_frame_core.sv
// Frame checking datapath: input register, header state, result register.
// Depends on sfc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sfc_frame_core (
    input  logic              clk,
    input  logic              rst_n,
    input  sfc_pkg::sfc_cfg_t cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  sfc_pkg::sfc_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output sfc_pkg::sfc_out_t out_data
);
    import sfc_pkg::*;

    // input register
    logic        in_valid_reg, in_valid_next;
    sfc_in_t     in_word_reg, in_word_next;
    // frame state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             magic_ok_reg, magic_ok_next;
    logic             version_ok_reg, version_ok_next;
    logic             kind_ok_reg, kind_ok_next;
    logic [7:0]       kind_reg, kind_next;
    logic [31:0]      decl_len_reg, decl_len_next;
    // result register
    logic        out_valid_reg, out_valid_next;
    sfc_out_t    out_word_reg, out_word_next;

    logic             advance;
    logic [7:0]       b;
    logic             last;
    logic             magic_upd, version_upd, kind_ok_upd;
    logic [7:0]       kind_upd;
    logic [31:0]      decl_upd;
    logic [1:0]       lane;
    logic             pay;
    logic [POS_W-1:0] pay_off;
    sfc_status_t      st;
    sfc_out_t         res;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    assign b       = in_word_reg.frame_byte;
    assign last    = in_word_reg.frame_end;
    assign lane    = pos_reg[1:0] + 2'd2;
    assign pay_off = pos_reg - HDR_LEN;

    // header field updates for the byte at hand
    always_comb
    begin
        magic_upd   = magic_ok_reg;
        version_upd = version_ok_reg;
        kind_ok_upd = kind_ok_reg;
        kind_upd    = kind_reg;
        decl_upd    = decl_len_reg;
        pay         = 1'b0;
        priority if (pos_reg < POS_VERSION)
        begin
            if (b != MAGIC[pos_reg[1:0]])
                magic_upd = 1'b0;
        end
        else if (pos_reg == POS_VERSION)
        begin
            version_upd = (b == VERSION_ONE);
        end
        else if (pos_reg == POS_KIND)
        begin
            kind_upd    = b;
            kind_ok_upd = (b == cfg.code_application) || (b == cfg.code_ping)
                       || (b == cfg.code_pong);
        end
        else if (pos_reg < HDR_LEN)
        begin
            decl_upd = decl_len_reg | (32'(b) << {lane, 3'b000});
        end
        else
        begin
            pay = magic_ok_reg && version_ok_reg && kind_ok_reg
               && (pay_off < POS_W'(decl_len_reg));
        end
    end

    // end-of-frame status; frame length equals pos + 1 (saturation never matches)
    always_comb
    begin
        priority if (pos_reg < LAST_HDR)
            st = ST_SHORT;
        else if (!magic_upd)
            st = ST_MAGIC;
        else if (!version_upd)
            st = ST_VERSION;
        else if (!kind_ok_upd)
            st = ST_KIND;
        else if (pos_reg != POS_W'(decl_upd) + LAST_HDR)
            st = ST_LEN_MISMATCH;
        else if (kind_upd == cfg.code_application)
            st = (decl_upd > cfg.max_app_payload) ? ST_APP_TOO_BIG : ST_OK;
        else
            st = (decl_upd != HB_LEN) ? ST_HB_SIZE : ST_OK;
    end

    always_comb
    begin
        res.payload_byte  = pay ? b : 8'd0;
        res.payload_valid = pay;
        res.frame_done    = last;
        res.status        = last ? st : ST_OK;
        res.kind_code     = (last && st == ST_OK) ? kind_upd : 8'd0;
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_word_next  = in_word_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
            in_word_next  = in_data;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        pos_next        = pos_reg;
        magic_ok_next   = magic_ok_reg;
        version_ok_next = version_ok_reg;
        kind_ok_next    = kind_ok_reg;
        kind_next       = kind_reg;
        decl_len_next   = decl_len_reg;
        if (advance)
        begin
            if (last)
            begin
                pos_next        = '0;
                magic_ok_next   = 1'b1;
                version_ok_next = 1'b0;
                kind_ok_next    = 1'b0;
                kind_next       = 8'd0;
                decl_len_next   = 32'd0;
            end
            else
            begin
                pos_next        = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POS_W'(1);
                magic_ok_next   = magic_upd;
                version_ok_next = version_upd;
                kind_ok_next    = kind_ok_upd;
                kind_next       = kind_upd;
                decl_len_next   = decl_upd;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (advance)
        begin
            out_valid_next = pay || last;
            out_word_next  = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            pos_reg        <= '0;
            magic_ok_reg   <= 1'b1;
            version_ok_reg <= 1'b0;
            kind_ok_reg    <= 1'b0;
            kind_reg       <= 8'd0;
            decl_len_reg   <= 32'd0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
            pos_reg        <= pos_next;
            magic_ok_reg   <= magic_ok_next;
            version_ok_reg <= version_ok_next;
            kind_ok_reg    <= kind_ok_next;
            kind_reg       <= kind_next;
            decl_len_reg   <= decl_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_word_reg  <= in_word_next;
        out_word_reg <= out_word_next;
    end

    `SFC_ASSERT_NOW(a_no_empty_result, clk, rst_n, out_valid_reg,
        out_word_reg.payload_valid || out_word_reg.frame_done)
    `SFC_ASSERT_NEXT(a_restart_after_end, clk, rst_n, advance && last,
        pos_reg == '0 && magic_ok_reg && !kind_ok_reg)
    `SFC_ASSERT_NEXT(a_pos_saturates, clk, rst_n,
        advance && !last && pos_reg == POS_MAX, pos_reg == POS_MAX)
    `SFC_ASSERT_NOW(a_kind_only_when_ok, clk, rst_n,
        out_valid_reg && out_word_reg.status != ST_OK, out_word_reg.kind_code == 8'd0)

endmodule

### rtl/stream_frame_checker_top.sv
// Top level of the stream frame checker.
// Depends on sfc_pkg, sfc_cfg_regs and sfc_frame_core.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one frame byte per word,
//   with frame_end set on the last byte of each frame. The header is 10 bytes:
//   magic "ATRN", version 1, a kind byte and a 32-bit little-endian length.
//   Output channel (out_valid/out_ready/out_data) carries one word per passed
//   payload byte and one word on the last byte of a frame; frame_done then
//   flags the status and, when the status is ok, the kind code.
//   Bytes that are neither passed payload nor a frame end produce no word.
//   Throughput: one byte per cycle, sustained while out_ready stays high, set by
//   the single pass from the input register through the header logic into the result register.
//   Path: a byte goes into the input register, its result into the result register.
//   Stall: while out_ready is low the result register holds its word and the
//   input register holds one more byte; in_ready drops only when both are full.
//   Reset: rst_n clears both stages and the frame state, and loads the
//   register defaults (max application payload 65536, codes 0, 1 and 2).
//   Configuration: APB registers at byte offsets 0, 4, 8, 12; write them only
//   while no frame byte is in flight.
module stream_frame_checker_top (
    input  logic                           clk,
    input  logic                           rst_n,
    // APB configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sfc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sfc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [sfc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    // byte stream in
    input  logic                           in_valid,
    output logic                           in_ready,
    input  sfc_pkg::sfc_in_t               in_data,
    // payload and status out
    output logic                           out_valid,
    input  logic                           out_ready,
    output sfc_pkg::sfc_out_t              out_data
);
    import sfc_pkg::*;

    // register file contents; the user must keep them stable while frames flow, the block does not enforce it
    sfc_cfg_t cfg;

    sfc_cfg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // check the header, advance the byte count, emit payload and status
    sfc_frame_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
